FILE: sv/surl_pkg.sv
// Shared types and codes for the sensor UART register link.
`default_nettype none

package surl_pkg;

   // Frame bytes on the serial line
   localparam logic [7:0] SEND_START  = 8'hAA;
   localparam logic [7:0] RECV_DATA   = 8'hBB;
   localparam logic [7:0] RECV_STATUS = 8'hEE;
   localparam logic [7:0] DIR_WRITE   = 8'h00;
   localparam logic [7:0] DIR_READ    = 8'h01;

   // Result kinds
   localparam logic [1:0] OUT_TX   = 2'd0;
   localparam logic [1:0] OUT_DATA = 2'd1;
   localparam logic [1:0] OUT_DONE = 2'd2;

   // Completion status codes
   localparam logic [1:0] ST_SUCCESS = 2'd0;
   localparam logic [1:0] ST_SYNC    = 2'd1;
   localparam logic [1:0] ST_DEVICE  = 2'd2;

   // Work queue depth and pointer widths
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Input word kinds
   typedef enum logic [1:0] {
      KIND_RX      = 2'd0,
      KIND_READ    = 2'd1,
      KIND_WRITE   = 2'd2,
      KIND_PAYLOAD = 2'd3
   } req_kind_type;

   // Deframer phases
   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   // Work classes handed from front to back
   typedef enum logic [1:0] {
      OP_CMD  = 2'd0,
      OP_TX   = 2'd1,
      OP_DATA = 2'd2,
      OP_DONE = 2'd3
   } op_type;

   // One queued work entry
   typedef struct packed {
      op_type     op;
      logic [7:0] value;     // tx byte, data byte or status byte
      logic [7:0] reg_addr;  // command register
      logic [7:0] xfer_len;  // command length
      logic       read_cmd;  // command direction is read
      logic [1:0] status;    // completion status for OP_DONE
      logic       done_tail; // data byte closes the frame
   } entry_type;

endpackage

`default_nettype wire

FILE: sv/surl_front.sv
// Front end: accepts words, runs the receive deframer, queues work entries.
`default_nettype none

module surl_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [1:0]          kind,
   input  wire logic [7:0]          byte_value,
   input  wire logic [7:0]          register_address,
   input  wire logic [7:0]          transfer_length,
   output logic                     push,
   output surl_pkg::entry_type      push_entry
);
   import surl_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] remain_ff, remain_in;
   logic       status_frame_ff, status_frame_in;
   logic [7:0] remain_dec;
   logic       is_rx;

   assign is_rx      = accept && (req_kind_type'(kind) == KIND_RX);
   assign remain_dec = remain_ff - 8'd1;

   // Next deframer state
   always_comb begin
      phase_in        = phase_ff;
      remain_in       = remain_ff;
      status_frame_in = status_frame_ff;
      if (is_rx) begin
         case (phase_ff)
            PH_LENGTH: begin
               if (status_frame_ff) begin
                  phase_in = PH_HEADER;
               end else if (byte_value == 8'd0) begin
                  phase_in  = PH_HEADER;
                  remain_in = 8'd0;
               end else begin
                  phase_in  = PH_PAYLOAD;
                  remain_in = byte_value;
               end
            end
            PH_PAYLOAD: begin
               remain_in = remain_dec;
               if (remain_dec == 8'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               if (byte_value == RECV_STATUS) begin
                  status_frame_in = 1'b1;
                  phase_in        = PH_LENGTH;
               end else if (byte_value == RECV_DATA) begin
                  status_frame_in = 1'b0;
                  phase_in        = PH_LENGTH;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   // Classify the accepted word into a work entry
   always_comb begin
      push                 = 1'b0;
      push_entry.op        = OP_TX;
      push_entry.value     = byte_value;
      push_entry.reg_addr  = register_address;
      push_entry.xfer_len  = transfer_length;
      push_entry.read_cmd  = (req_kind_type'(kind) == KIND_READ);
      push_entry.status    = ST_SUCCESS;
      push_entry.done_tail = 1'b0;
      case (req_kind_type'(kind))
         KIND_READ, KIND_WRITE: begin
            push          = accept;
            push_entry.op = OP_CMD;
         end
         KIND_PAYLOAD: begin
            push          = accept;
            push_entry.op = OP_TX;
         end
         default: begin
            case (phase_ff)
               PH_LENGTH: begin
                  if (status_frame_ff) begin
                     push              = accept;
                     push_entry.op     = OP_DONE;
                     push_entry.status = ST_DEVICE;
                  end else if (byte_value == 8'd0) begin
                     push              = accept;
                     push_entry.op     = OP_DONE;
                     push_entry.value  = 8'd0;
                  end
               end
               PH_PAYLOAD: begin
                  push                 = accept;
                  push_entry.op        = OP_DATA;
                  push_entry.done_tail = (remain_dec == 8'd0);
               end
               default: begin
                  if (byte_value != RECV_STATUS && byte_value != RECV_DATA) begin
                     push              = accept;
                     push_entry.op     = OP_DONE;
                     push_entry.value  = 8'd0;
                     push_entry.status = ST_SYNC;
                  end
               end
            endcase
         end
      endcase
   end

   // Hold deframer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         remain_ff       <= 8'd0;
         status_frame_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         remain_ff       <= remain_in;
         status_frame_ff <= status_frame_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/surl_queue.sv
// Short work queue between the front end and the result sequencer.
`default_nettype none

module surl_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire surl_pkg::entry_type push_entry,
   input  wire logic                pop,
   output logic                     full,
   output logic                     head_valid,
   output surl_pkg::entry_type      head_entry
);
   import surl_pkg::*;

   entry_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: sv/surl_back.sv
// Back end: expands queued entries into result words through an output register.
`default_nettype none

module surl_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire surl_pkg::entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_byte,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);
   import surl_pkg::*;

   logic [1:0] beat_ff, beat_in;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;
   logic       load, fire;

   assign load = !valid_ff || rsp_tready;
   assign fire = load && head_valid;
   assign pop  = fire && last_in;

   // Pick the result word for the current beat of the head entry
   always_comb begin
      kind_in   = OUT_TX;
      byte_in   = head_entry.value;
      status_in = ST_SUCCESS;
      last_in   = 1'b1;
      case (head_entry.op)
         OP_CMD: begin
            last_in = (beat_ff == 2'd3);
            case (beat_ff)
               2'd0:    byte_in = SEND_START;
               2'd1:    byte_in = head_entry.read_cmd ? DIR_READ : DIR_WRITE;
               2'd2:    byte_in = head_entry.reg_addr;
               default: byte_in = head_entry.xfer_len;
            endcase
         end
         OP_DATA: begin
            if (beat_ff == 2'd0) begin
               kind_in = OUT_DATA;
               last_in = !head_entry.done_tail;
            end else begin
               kind_in = OUT_DONE;
               byte_in = 8'd0;
            end
         end
         OP_DONE: begin
            kind_in   = OUT_DONE;
            status_in = head_entry.status;
         end
         default: begin
            kind_in = OUT_TX;
         end
      endcase
   end

   // Advance beat and output valid
   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = head_valid;
      end
      if (fire) begin
         beat_in = last_in ? 2'd0 : beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   // Load output payload
   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

   a_beat_has_head: assert property (@(posedge clock) disable iff (reset)
      beat_ff != 2'd0 |-> head_valid)
      else $error("beat in progress without a queued entry");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !last_ff && rsp_tready |=> valid_ff)
      else $error("gap inside a multi-word result");

   a_pop_on_load: assert property (@(posedge clock) disable iff (reset)
      pop |-> load && head_valid)
      else $error("entry dropped without output load");

   a_tail_beats: assert property (@(posedge clock) disable iff (reset)
      head_valid && head_entry.op != OP_CMD |-> beat_ff <= 2'd1)
      else $error("non-command entry past its second beat");

endmodule

`default_nettype wire

FILE: sv/sensor_uart_register_link.sv
// Top level of the sensor UART register link.
//
//   port group | dir | tdata (low bit up)                         | tuser / tlast
//   req_*      | in  | byte_value, register_address, transfer_len | kind
//   rsp_*      | out | out_byte, completion_status, 6'b0          | out_kind / last
//
// The front end takes one word per cycle while the four-entry work queue has room.
// Each queued entry leaves the output register one word per cycle unless rsp stalls: a
// command gives four words, a frame-closing data byte two, every other entry one.
// Words that cause no result (frame headers, nonzero length bytes) queue no entry.
// Synchronous reset empties the queue, drops the output word and returns the
// deframer to awaiting a header; a stalled rsp side backs up into the queue.
`default_nettype none

module sensor_uart_register_link (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // byte_value, register_address, transfer_length
   input  wire logic [1:0]  req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // out_byte, completion_status, zero pad
   output logic [1:0]       rsp_tuser,  // out_kind
   output logic             rsp_tlast   // last
);
   import surl_pkg::*;

   logic       accept;
   logic       push, pop, full, head_valid;
   entry_type  push_entry, head_entry;
   logic [7:0] rsp_byte;
   logic [1:0] rsp_status;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   surl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .kind             (req_tuser),
      .byte_value       (req_tdata[7:0]),
      .register_address (req_tdata[15:8]),
      .transfer_length  (req_tdata[23:16]),
      .push             (push),
      .push_entry       (push_entry)
   );

   surl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   surl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_byte   (rsp_byte),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_tlast)
   );

   // Pack the result word
   assign rsp_tdata = {6'd0, rsp_status, rsp_byte};

endmodule

`default_nettype wire

FILE: tb/tb_sensor_uart_register_link.sv
// Self-checking testbench for the sensor UART register link: scoreboard with its own predictor.
`default_nettype none

module tb_sensor_uart_register_link;
   import surl_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_WORDS = 105;

   // One expected response word
   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] status;
      logic       tail;
   } rsp_word_type;

   // Predicts the link's response words and checks them in order
   class link_scoreboard;
      phase_type     rx_phase;
      logic [7:0]    bytes_left;
      logic          in_status_frame;
      rsp_word_type  words_due[$];
      rsp_word_type  fresh[$];
      int            errors;

      function new();
         rx_phase        = PH_HEADER;
         bytes_left      = 8'd0;
         in_status_frame = 1'b0;
         errors          = 0;
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] data, logic [1:0] status);
         rsp_word_type w;
         w.kind   = kind;
         w.data   = data;
         w.status = status;
         w.tail   = 1'b0;
         fresh.push_back(w);
      endfunction

      // Advance the deframer by one received byte
      function void take_rx_byte(logic [7:0] b);
         case (rx_phase)
            PH_LENGTH: begin
               if (in_status_frame) begin
                  rx_phase = PH_HEADER;
                  emit(OUT_DONE, b, ST_DEVICE);
               end else if (b == 8'd0) begin
                  // zero length closes the frame at once
                  rx_phase   = PH_HEADER;
                  bytes_left = 8'd0;
                  emit(OUT_DONE, 8'd0, ST_SUCCESS);
               end else begin
                  bytes_left = b;
                  rx_phase   = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               emit(OUT_DATA, b, ST_SUCCESS);
               bytes_left = bytes_left - 8'd1;
               if (bytes_left == 8'd0) begin
                  rx_phase = PH_HEADER;
                  emit(OUT_DONE, 8'd0, ST_SUCCESS);
               end
            end
            default: begin
               if (b == RECV_STATUS) begin
                  in_status_frame = 1'b1;
                  rx_phase        = PH_LENGTH;
               end else if (b == RECV_DATA) begin
                  in_status_frame = 1'b0;
                  rx_phase        = PH_LENGTH;
               end else begin
                  rx_phase = PH_HEADER;
                  emit(OUT_DONE, 8'd0, ST_SYNC);
               end
            end
         endcase
      endfunction

      // Note an accepted request word and queue the words it causes
      function void note_request(req_kind_type kind, logic [7:0] value,
                                 logic [7:0] reg_addr, logic [7:0] xfer_len);
         fresh.delete();
         case (kind)
            KIND_RX:      take_rx_byte(value);
            KIND_PAYLOAD: emit(OUT_TX, value, ST_SUCCESS);
            default: begin
               emit(OUT_TX, SEND_START, ST_SUCCESS);
               emit(OUT_TX, (kind == KIND_READ) ? DIR_READ : DIR_WRITE, ST_SUCCESS);
               emit(OUT_TX, reg_addr, ST_SUCCESS);
               emit(OUT_TX, xfer_len, ST_SUCCESS);
            end
         endcase
         if (fresh.size() > 0) fresh[fresh.size() - 1].tail = 1'b1;
         foreach (fresh[i]) words_due.push_back(fresh[i]);
      endfunction

      // Compare one accepted response word with the oldest expectation
      function void check_response(logic [1:0] kind, logic [7:0] data,
                                   logic [1:0] status, logic tail);
         rsp_word_type w;
         if (words_due.size() == 0) begin
            $error("unexpected response word: kind %0d byte 0x%02h status %0d last %0d",
                   kind, data, status, tail);
            errors++;
            return;
         end
         w = words_due.pop_front();
         if (kind !== w.kind) begin
            $error("out_kind: expected %0d, got %0d", w.kind, kind);
            errors++;
         end
         if (data !== w.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", w.data, data);
            errors++;
         end
         if (status !== w.status) begin
            $error("completion_status: expected %0d, got %0d", w.status, status);
            errors++;
         end
         if (tail !== w.tail) begin
            $error("last: expected %0d, got %0d", w.tail, tail);
            errors++;
         end
      endfunction

      function int pending();
         return words_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = 24'd0;  // byte_value, register_address, transfer_length
   logic [1:0]  req_tuser = 2'd0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // out_byte, completion_status, zero pad
   logic [1:0]  rsp_tuser;          // out_kind
   logic        rsp_tlast;          // last

   link_scoreboard sb = new();
   int  cycle_count = 0;
   int  words_sent = 0;
   bit  req_quiet = 1'b0;
   bit  rsp_quiet = 1'b0;
   int  rsp_stall = 0;

   sensor_uart_register_link i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Idle length: mostly none or short, now and then long
   function automatic int idle_len(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: check accepted words, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata[7:0], rsp_tdata[9:8], rsp_tlast);
         if ($urandom_range(0, 99) == 0) rsp_quiet = !rsp_quiet;
         if (rsp_stall > 0)
            rsp_stall--;
         else if ((rsp_tvalid && rsp_tready) || $urandom_range(0, 15) == 0)
            rsp_stall = idle_len(rsp_quiet);
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // Offer one request word after a random gap and hold it until accepted
   task automatic send_word(req_kind_type kind, logic [7:0] value,
                            logic [7:0] reg_addr, logic [7:0] xfer_len);
      int gap;
      gap = idle_len(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {xfer_len, reg_addr, value};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, value, reg_addr, xfer_len);
      words_sent++;
   endtask

   // Hold off the sender until every expected word has come back
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   task automatic send_rx(logic [7:0] b);
      send_word(KIND_RX, b, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // Random command or write payload word
   task automatic send_tx_word();
      send_word(req_kind_type'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int seq;
      int choice;
      int len;
      int noise;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every kind, frame corner cases
      send_word(KIND_READ, 8'h00, 8'h00, 8'h00);
      send_word(KIND_WRITE, 8'h00, 8'hFF, 8'hFF);
      send_word(KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
      send_word(KIND_PAYLOAD, 8'hFF, 8'h00, 8'h00);
      send_word(KIND_RX, 8'h00, 8'h00, 8'h00);
      send_word(KIND_RX, 8'hFF, 8'h00, 8'h00);
      send_word(KIND_RX, SEND_START, 8'h00, 8'h00);
      // zero-length data frame
      send_word(KIND_RX, RECV_DATA, 8'h00, 8'h00);
      send_word(KIND_RX, 8'h00, 8'h00, 8'h00);
      // one-byte data frame
      send_word(KIND_RX, RECV_DATA, 8'h00, 8'h00);
      send_word(KIND_RX, 8'h01, 8'h00, 8'h00);
      send_word(KIND_RX, 8'hFF, 8'h00, 8'h00);
      // status frames with extreme codes
      send_word(KIND_RX, RECV_STATUS, 8'h00, 8'h00);
      send_word(KIND_RX, 8'h00, 8'h00, 8'h00);
      send_word(KIND_RX, RECV_STATUS, 8'h00, 8'h00);
      send_word(KIND_RX, 8'hFF, 8'h00, 8'h00);
      // commands and payload in the middle of a data frame
      send_word(KIND_RX, RECV_DATA, 8'h00, 8'h00);
      send_word(KIND_RX, 8'h02, 8'h00, 8'h00);
      send_word(KIND_READ, 8'h00, 8'h5A, 8'hA5);
      send_word(KIND_RX, 8'h11, 8'h00, 8'h00);
      send_word(KIND_PAYLOAD, 8'h3C, 8'h00, 8'h00);
      send_word(KIND_WRITE, 8'h00, 8'h81, 8'h7E);
      send_word(KIND_RX, 8'h22, 8'h00, 8'h00);
      // header value as a status code
      send_word(KIND_RX, RECV_STATUS, 8'h00, 8'h00);
      send_word(KIND_RX, RECV_DATA, 8'h00, 8'h00);
      wait_for_responses();

      // Random traffic, mostly well-formed frames
      words_sent = 0;
      seq = 0;
      while (words_sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 5) == 0) req_quiet = !req_quiet;
         if (seq == 25 || seq == 50) wait_for_responses();
         choice = $urandom_range(0, 99);
         if (choice < 35) begin
            // data frame, the odd one long
            if ($urandom_range(0, 15) == 0) len = $urandom_range(7, 20);
            else len = $urandom_range(0, 5);
            send_rx(RECV_DATA);
            send_rx(8'(len));
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 7) == 0) send_tx_word();
               send_rx(8'($urandom_range(0, 255)));
            end
         end else if (choice < 50) begin
            send_rx(RECV_STATUS);
            send_rx(8'($urandom_range(0, 255)));
         end else if (choice < 70) begin
            send_word(req_kind_type'($urandom_range(1, 2)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4)) send_tx_word();
         end else if (choice < 78) begin
            send_word(KIND_PAYLOAD, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (choice < 90) begin
            // noise byte, sometimes a header
            noise = $urandom_range(0, 3);
            if (noise == 0) send_rx(RECV_DATA);
            else if (noise == 1) send_rx(RECV_STATUS);
            else send_rx(8'($urandom_range(0, 255)));
         end else begin
            // broken frame: header and a truncated tail
            send_rx($urandom_range(0, 1) ? RECV_DATA : RECV_STATUS);
            repeat ($urandom_range(0, 2)) send_rx(8'($urandom_range(0, 255)));
         end
         seq++;
      end

      // Drain and let any stray words show up
      wait_for_responses();
      repeat (64) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
